@@ sv/cfilt_pkg.sv @@
// Shared constants, types, the atan table function and a saturation helper for the complementary tilt filter.
package cfilt_pkg;

    localparam int CORDIC_STEPS_DEF  = 16;
    localparam int ANGLE_FRAC_DEF    = 16;

    localparam int IN_W      = 128;
    localparam int OUT_W     = 152;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_GYRO_COUNTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_WEIGHT = 2'd1;

    localparam logic [15:0] GYRO_COUNTS_RST = 16'd1310;
    localparam logic [15:0] GYRO_WEIGHT_RST = 16'd64225;

    localparam logic [1:0] AXIS_ROLL  = 2'd0;
    localparam logic [1:0] AXIS_PITCH = 2'd1;
    localparam logic [1:0] AXIS_YAW   = 2'd2;

    // CORDIC datapath width, Q16.16 angle width before clamping
    localparam int CW    = 34;
    localparam int Q16W  = 27;
    localparam int SQ_W  = 60;
    localparam int SQ_RW = 30;
    localparam int SQ_STEPS = 30;

    localparam int DIV_W  = 23;
    localparam int DIV_QW = 41;
    localparam int INC_W  = 42;

    localparam logic signed [Q16W-1:0] ROLL_LIMIT  = 27'sd11796480;
    localparam logic signed [Q16W-1:0] PITCH_LIMIT = 27'sd5898240;

    localparam logic [63:0] DEG_PER_RAD_Q32 = 64'd246083499207;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ROLL_GO, ST_ROLL_WAIT, ST_SQRT_GO, ST_SQRT_WAIT,
        ST_PITCH_GO, ST_PITCH_WAIT, ST_GYRO_GO, ST_GYRO_WAIT,
        ST_BLEND_G, ST_BLEND_A, ST_BLEND_SUM, ST_YAW, ST_DONE
    } seq_state_t;

    typedef enum logic [2:0] {
        DIV_IDLE, DIV_MUL, DIV_LOAD, DIV_RUN, DIV_DONE
    } div_phase_t;

    typedef struct packed {
        logic s_ready;
        logic cordic_go;
        logic cordic_pitch;
        logic sqrt_go;
        logic gyro_go;
    } seq_ctl_t;

    // atan(2^-i) in degrees, series in Q32, rounded to frac fraction bits
    function automatic logic [63:0] atan_step_q(input int unsigned i, input int unsigned frac);
        logic [63:0] q32;
        longint acc;
        longint term;
        int unsigned k;
        int unsigned odd;
        acc = 0;
        q32 = 64'd0;
        if (i == 0) begin
            q32 = 64'd45 << 32;
        end else begin
            for (k = 0; (2 * k + 1) * i < 40; k++) begin
                odd  = 2 * k + 1;
                term = longint'((DEG_PER_RAD_Q32 >> (odd * i)) / 64'(odd));
                if (k[0]) begin
                    acc = acc - term;
                end else begin
                    acc = acc + term;
                end
            end
            q32 = 64'(acc);
        end
        return (q32 + (64'd1 << (31 - frac))) >> (32 - frac);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
        if (v > 43'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -43'sd2147483648) begin
            return 32'sh80000000;
        end
        return 32'(v);
    endfunction

endpackage

@@ sv/cfilt_cordic.sv @@
// Iterative vectoring CORDIC giving atan2(y, x) in Q16.16 degrees.
module cfilt_cordic #(
    parameter int CORDIC_STEPS        = cfilt_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRACTION_BITS = cfilt_pkg::ANGLE_FRAC_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [cfilt_pkg::CW-1:0]   y_in,
    input  logic signed [cfilt_pkg::CW-1:0]   x_in,
    output logic                              done,
    output logic signed [cfilt_pkg::Q16W-1:0] angle_q16
);
    import cfilt_pkg::*;

    localparam int AW = ANGLE_FRACTION_BITS + 7;
    localparam int ZW = ANGLE_FRACTION_BITS + 10;
    localparam int IW = $clog2(CORDIC_STEPS);
    localparam logic signed [ZW-1:0] Z180 = ZW'(180) << ANGLE_FRACTION_BITS;

    logic [AW-1:0]          atan_tab [CORDIC_STEPS];
    logic signed [CW-1:0]   x_reg, y_reg, xs, ys;
    logic signed [ZW-1:0]   z_reg, ang;
    logic [IW-1:0]          idx_reg;
    logic                   run_reg, done_reg;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_atan
        localparam logic [63:0] AQ = atan_step_q(g, ANGLE_FRACTION_BITS);
        assign atan_tab[g] = AW'(AQ);
    end

    assign xs  = x_reg >>> idx_reg;
    assign ys  = y_reg >>> idx_reg;
    assign ang = ZW'(atan_tab[idx_reg]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg  <= (y_in != '0);
                done_reg <= (y_in == '0);
                idx_reg  <= '0;
            end else if (run_reg) begin
                if (idx_reg == IW'(CORDIC_STEPS - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                    idx_reg  <= '0;
                end else begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            if (x_in < 0) begin
                x_reg <= -x_in;
                y_reg <= -y_in;
                z_reg <= (y_in >= 0) ? Z180 : -Z180;
            end else begin
                x_reg <= x_in;
                y_reg <= y_in;
                z_reg <= '0;
            end
        end else if (run_reg) begin
            if (y_reg > 0) begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + ang;
            end else begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - ang;
            end
        end
    end

    // rescale to Q16.16, half up when dropping bits
    if (ANGLE_FRACTION_BITS > 16) begin : g_down
        localparam int SH = ANGLE_FRACTION_BITS - 16;
        logic signed [ZW-1:0] zr;
        assign zr        = z_reg + ZW'(1 << (SH - 1));
        assign angle_q16 = Q16W'(zr >>> SH);
    end else if (ANGLE_FRACTION_BITS < 16) begin : g_up
        logic signed [Q16W-1:0] ze;
        assign ze        = Q16W'(z_reg);
        assign angle_q16 = ze <<< (16 - ANGLE_FRACTION_BITS);
    end else begin : g_same
        assign angle_q16 = Q16W'(z_reg);
    end

    assign done = done_reg;

endmodule

@@ sv/cfilt_isqrt.sv @@
// Bit-pair integer square root, one result bit per cycle.
module cfilt_isqrt (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [cfilt_pkg::SQ_W-1:0]     n_in,
    output logic                           done,
    output logic [cfilt_pkg::SQ_RW-1:0]    root
);
    import cfilt_pkg::*;

    localparam int CNW = $clog2(SQ_STEPS);

    logic [SQ_W-1:0] n_reg, r_reg, bit_reg;
    logic [SQ_W:0]   trial;
    logic [CNW-1:0]  cnt_reg;
    logic            run_reg, done_reg;

    assign trial = {1'b0, r_reg} + {1'b0, bit_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                if (cnt_reg == CNW'(SQ_STEPS - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg   <= n_in;
            r_reg   <= '0;
            bit_reg <= SQ_W'(1) << (SQ_W - 2);
        end else if (run_reg) begin
            if ({1'b0, n_reg} >= trial) begin
                n_reg <= n_reg - trial[SQ_W-1:0];
                r_reg <= (r_reg >> 1) + bit_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = r_reg[SQ_RW-1:0];

endmodule

@@ sv/cfilt_gyro_div.sv @@
// Gyro angle increment: rate times dt, scaled, by restoring division.
module cfilt_gyro_div (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [15:0]                 raw,
    input  logic [31:0]                        dt,
    input  logic [15:0]                        counts,
    output logic                               done,
    output logic signed [cfilt_pkg::INC_W-1:0] inc
);
    import cfilt_pkg::*;

    localparam int CNW = $clog2(DIV_QW);
    localparam logic [DIV_QW-1:0] Q_LIMIT = DIV_QW'(1) << (DIV_QW - 1);

    div_phase_t       phase_reg, phase_next;
    logic [CNW-1:0]   cnt_reg;
    logic             neg_reg, sat_reg;
    logic [15:0]      mag_reg, counts_eff;
    logic [31:0]      dt_reg;
    logic [DIV_W-1:0] div_reg;
    logic [47:0]      prod_reg;
    logic [63:0]      nh;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W:0]   trial;
    logic [DIV_QW-1:0] bits_reg, q_reg, q_lim;

    assign counts_eff = (counts == 16'd0) ? 16'd1 : counts;
    assign nh    = {prod_reg, 16'd0} + 64'(div_reg >> 1);
    assign trial = {rem_reg, bits_reg[DIV_QW-1]};

    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            DIV_IDLE: if (start) phase_next = DIV_MUL;
            DIV_MUL:  phase_next = DIV_LOAD;
            DIV_LOAD: phase_next = DIV_RUN;
            DIV_RUN:  if (cnt_reg == CNW'(DIV_QW - 1)) phase_next = DIV_DONE;
            DIV_DONE: phase_next = DIV_IDLE;
            default:  phase_next = DIV_IDLE;
        endcase
    end

    always_comb begin
        done = (phase_reg == DIV_DONE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= DIV_IDLE;
            cnt_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            if (phase_reg == DIV_RUN) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else begin
                cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (phase_reg)
            DIV_IDLE: begin
                neg_reg <= raw[15];
                mag_reg <= raw[15] ? (~raw + 16'd1) : raw;
                dt_reg  <= dt;
                div_reg <= DIV_W'(counts_eff) * DIV_W'(100);
            end
            DIV_MUL: prod_reg <= 48'(mag_reg) * 48'(dt_reg);
            DIV_LOAD: begin
                rem_reg  <= nh[63:DIV_QW];
                sat_reg  <= (nh[63:DIV_QW] >= div_reg);
                bits_reg <= nh[DIV_QW-1:0];
                q_reg    <= '0;
            end
            DIV_RUN: begin
                if (trial >= {1'b0, div_reg}) begin
                    rem_reg <= DIV_W'(trial - {1'b0, div_reg});
                    q_reg   <= {q_reg[DIV_QW-2:0], 1'b1};
                end else begin
                    rem_reg <= trial[DIV_W-1:0];
                    q_reg   <= {q_reg[DIV_QW-2:0], 1'b0};
                end
                bits_reg <= bits_reg << 1;
            end
            default: ;
        endcase
    end

    assign q_lim = (sat_reg || q_reg > Q_LIMIT) ? Q_LIMIT : q_reg;
    assign inc   = neg_reg ? -$signed({1'b0, q_lim}) : $signed({1'b0, q_lim});

endmodule

@@ sv/imu_complementary_tilt_filter_core.sv @@
// Complementary roll/pitch/yaw tilt filter top level with sequencer and blend datapath.
//
//  channel | dir | handshake         | payload
//  s_      | in  | s_tvalid/s_tready | s_tdata: accel x,y,z, gyro x,y,z, time_ms
//  m_      | out | m_tvalid/m_tready | m_tdata: roll, pitch, yaw, accel roll, accel pitch
//  cfg_    | in  | cfg_we            | cfg_index, cfg_wdata
//
// Each sample takes two CORDIC runs, a square root and three gyro divisions, which dominate.
// aresetn is synchronous: clears angles, previous timestamp and registers to defaults.
// s_tready is high only while idle; a finished result waits in the output register
// while the next sample is accepted, and completion stalls until that result is taken.
module imu_complementary_tilt_filter_core #(
    parameter int CORDIC_STEPS        = cfilt_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRACTION_BITS = cfilt_pkg::ANGLE_FRAC_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [cfilt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cfilt_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 each), time_ms (32)
    input  logic [cfilt_pkg::IN_W-1:0]        s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // roll_deg, pitch_deg, yaw_deg (32 each), accel_roll_deg (25), accel_pitch_deg (24), pad
    output logic [cfilt_pkg::OUT_W-1:0]       m_tdata
);
    import cfilt_pkg::*;

    seq_state_t state_reg, state_next;
    seq_ctl_t   ctl;

    logic [15:0] counts_reg, weight_reg;
    logic [31:0] prev_time_reg, dt_reg;
    logic signed [31:0] roll_reg, pitch_reg, yaw_reg;
    logic [1:0]  axis_reg;
    logic signed [15:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg, gz_reg;
    logic signed [24:0] xl_roll_reg;
    logic signed [23:0] xl_pitch_reg;
    logic signed [INC_W-1:0] inc_x_reg, inc_y_reg, inc_z_reg;
    logic signed [48:0] p1_reg;
    logic signed [42:0] p2_reg;
    logic               m_tvalid_reg;
    logic [OUT_W-1:0]   m_tdata_reg;

    logic signed [CW-1:0]   cy, cx;
    logic                   cordic_done, sqrt_done, gyro_done;
    logic signed [Q16W-1:0] angle_q16;
    logic [SQ_RW-1:0]       root;
    logic signed [31:0]     ay2, az2;
    logic [31:0]            sumsq;
    logic signed [15:0]     gyro_raw;
    logic signed [INC_W-1:0] gyro_inc;

    logic signed [31:0]      sel_state, g_val, blend_val;
    logic signed [INC_W-1:0] sel_inc;
    logic signed [24:0]      sel_acc;
    logic signed [16:0]      w_s;
    logic signed [17:0]      aw_s;
    logic signed [50:0]      blend_sum;
    logic signed [34:0]      blend_sh;

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:       if (s_tvalid) state_next = ST_ROLL_GO;
            ST_ROLL_GO:    state_next = ST_ROLL_WAIT;
            ST_ROLL_WAIT:  if (cordic_done) state_next = ST_SQRT_GO;
            ST_SQRT_GO:    state_next = ST_SQRT_WAIT;
            ST_SQRT_WAIT:  if (sqrt_done) state_next = ST_PITCH_GO;
            ST_PITCH_GO:   state_next = ST_PITCH_WAIT;
            ST_PITCH_WAIT: if (cordic_done) state_next = ST_GYRO_GO;
            ST_GYRO_GO:    state_next = ST_GYRO_WAIT;
            ST_GYRO_WAIT: begin
                if (gyro_done) begin
                    state_next = (axis_reg == AXIS_YAW) ? ST_BLEND_G : ST_GYRO_GO;
                end
            end
            ST_BLEND_G:    state_next = ST_BLEND_A;
            ST_BLEND_A:    state_next = ST_BLEND_SUM;
            ST_BLEND_SUM:  state_next = (axis_reg == AXIS_PITCH) ? ST_YAW : ST_BLEND_G;
            ST_YAW:        state_next = ST_DONE;
            ST_DONE:       if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctl = '0;
        case (state_reg)
            ST_IDLE:     ctl.s_ready = 1'b1;
            ST_ROLL_GO:  ctl.cordic_go = 1'b1;
            ST_SQRT_GO:  ctl.sqrt_go = 1'b1;
            ST_PITCH_GO: begin
                ctl.cordic_go    = 1'b1;
                ctl.cordic_pitch = 1'b1;
            end
            ST_GYRO_GO:  ctl.gyro_go = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = ctl.s_ready;

    // arithmetic units; the CORDIC and the gyro divider are shared
    assign cy = ctl.cordic_pitch ? (-CW'(ax_reg)) <<< 14 : CW'(ay_reg) <<< 14;
    assign cx = ctl.cordic_pitch ? CW'({1'b0, root}) : CW'(az_reg) <<< 14;

    cfilt_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS),
        .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)
    ) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(ctl.cordic_go),
        .y_in(cy), .x_in(cx), .done(cordic_done), .angle_q16(angle_q16)
    );

    assign ay2   = ay_reg * ay_reg;
    assign az2   = az_reg * az_reg;
    assign sumsq = ay2 + az2;

    cfilt_isqrt u_isqrt (
        .aclk(aclk), .aresetn(aresetn), .start(ctl.sqrt_go),
        .n_in({sumsq, 28'd0}), .done(sqrt_done), .root(root)
    );

    always_comb begin
        case (axis_reg)
            AXIS_ROLL:  gyro_raw = gx_reg;
            AXIS_PITCH: gyro_raw = gy_reg;
            default:    gyro_raw = gz_reg;
        endcase
    end

    cfilt_gyro_div u_gyro (
        .aclk(aclk), .aresetn(aresetn), .start(ctl.gyro_go),
        .raw(gyro_raw), .dt(dt_reg), .counts(counts_reg),
        .done(gyro_done), .inc(gyro_inc)
    );

    // blend datapath
    assign sel_state = (axis_reg == AXIS_ROLL) ? roll_reg : pitch_reg;
    assign sel_inc   = (axis_reg == AXIS_ROLL) ? inc_x_reg : inc_y_reg;
    assign sel_acc   = (axis_reg == AXIS_ROLL) ? xl_roll_reg : 25'(xl_pitch_reg);
    assign g_val     = sat32(43'(sel_state) + 43'(sel_inc));
    assign w_s       = $signed({1'b0, weight_reg});
    assign aw_s      = 18'sd65536 - 18'(w_s);
    assign blend_sum = 51'(p1_reg) + 51'(p2_reg) + 51'sd32768;
    assign blend_sh  = 35'(blend_sum >>> 16);
    assign blend_val = sat32(43'(blend_sh));

    // control and angle state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counts_reg    <= GYRO_COUNTS_RST;
            weight_reg    <= GYRO_WEIGHT_RST;
            prev_time_reg <= '0;
            roll_reg      <= '0;
            pitch_reg     <= '0;
            yaw_reg       <= '0;
            axis_reg      <= AXIS_ROLL;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_GYRO_COUNTS: counts_reg <= cfg_wdata;
                    REG_GYRO_WEIGHT: weight_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && ctl.s_ready) begin
                prev_time_reg <= s_tdata[127:96];
                axis_reg      <= AXIS_ROLL;
            end
            if (state_reg == ST_GYRO_WAIT && gyro_done) begin
                axis_reg <= (axis_reg == AXIS_YAW) ? AXIS_ROLL : axis_reg + 2'd1;
            end
            if (state_reg == ST_BLEND_SUM) begin
                if (axis_reg == AXIS_ROLL) begin
                    roll_reg <= blend_val;
                    axis_reg <= AXIS_PITCH;
                end else begin
                    pitch_reg <= blend_val;
                end
            end
            if (state_reg == ST_YAW) begin
                yaw_reg <= sat32(43'(yaw_reg) + 43'(inc_z_reg));
            end
            if (state_reg == ST_DONE && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload, intermediate results and output data
    always_ff @(posedge aclk) begin
        if (s_tvalid && ctl.s_ready) begin
            ax_reg <= s_tdata[15:0];
            ay_reg <= s_tdata[31:16];
            az_reg <= s_tdata[47:32];
            gx_reg <= s_tdata[63:48];
            gy_reg <= s_tdata[79:64];
            gz_reg <= s_tdata[95:80];
            dt_reg <= (prev_time_reg == 32'd0) ? 32'd0 : s_tdata[127:96] - prev_time_reg;
        end
        if (state_reg == ST_ROLL_WAIT && cordic_done) begin
            if (angle_q16 > ROLL_LIMIT) begin
                xl_roll_reg <= 25'(ROLL_LIMIT);
            end else if (angle_q16 < -ROLL_LIMIT) begin
                xl_roll_reg <= 25'(-ROLL_LIMIT);
            end else begin
                xl_roll_reg <= 25'(angle_q16);
            end
        end
        if (state_reg == ST_PITCH_WAIT && cordic_done) begin
            if (angle_q16 > PITCH_LIMIT) begin
                xl_pitch_reg <= 24'(PITCH_LIMIT);
            end else if (angle_q16 < -PITCH_LIMIT) begin
                xl_pitch_reg <= 24'(-PITCH_LIMIT);
            end else begin
                xl_pitch_reg <= 24'(angle_q16);
            end
        end
        if (state_reg == ST_GYRO_WAIT && gyro_done) begin
            case (axis_reg)
                AXIS_ROLL:  inc_x_reg <= gyro_inc;
                AXIS_PITCH: inc_y_reg <= gyro_inc;
                default:    inc_z_reg <= gyro_inc;
            endcase
        end
        if (state_reg == ST_BLEND_G) begin
            p1_reg <= w_s * g_val;
        end
        if (state_reg == ST_BLEND_A) begin
            p2_reg <= aw_s * sel_acc;
        end
        if (state_reg == ST_DONE && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= {7'd0, xl_pitch_reg, xl_roll_reg, yaw_reg, pitch_reg, roll_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ sv/cfilt_checker.sv @@
// Port-level checks for the tilt filter core, bound to the top level.
module cfilt_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [cfilt_pkg::OUT_W-1:0]     m_tdata
);
    // request accepted: busy on the next cycle
    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("s_tready high right after a request");

    // a new result only comes out of a busy sequence
    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while idle");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[144:121]) <= 24'sd5898240)
                  && ($signed(m_tdata[144:121]) >= -24'sd5898240))
        else $error("accel pitch out of range");

endmodule

bind imu_complementary_tilt_filter_core cfilt_checker u_cfilt_checker (.*);
